// File: sv/mfsk_tone_sample_synthesizer_defines.svh
// Assertion macros shared by the synthesizer RTL.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef MFSK_TONE_SAMPLE_SYNTHESIZER_DEFINES_SVH
`define MFSK_TONE_SAMPLE_SYNTHESIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MFSK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MFSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFSK_ASSERT_IMPL(lbl, ante, cons, msg)
`define MFSK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/mfsk_tss_pkg.sv
package mfsk_tss_pkg;

  // Item kinds on the input stream
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_STEP  = 2'd0;
  localparam logic [1:0] CFG_TONE_STEP  = 2'd1;
  localparam logic [1:0] CFG_SPS        = 2'd2;
  localparam logic [1:0] CFG_TOTAL      = 2'd3;

  // Result FIFO depth; the credit check keeps it from overflowing
  localparam int unsigned FIFO_DEPTH = 4;

  // Q30 constants for the sine table build
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Side info that travels with a sample down the sine pipe
  typedef struct packed {
    logic last;
    logic exhausted;
  } sample_meta_t;

  // One finished result
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        exhausted;
  } out_item_t;

  // Q15 magnitude of sin(q * (pi/2) / 2^(idx_bits-2)); Taylor series to x^11
  // in Horner form with truncating shifts, round half up, limit to 32767.
  // Only called with constant arguments to build the quarter-wave ROM.
  function automatic logic [14:0] quarter_sine(input int unsigned q,
                                               input int unsigned idx_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(q) * HALF_PI_Q30) >> (idx_bits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

// File: sv/mfsk_tone_sample_synthesizer.sv
// A sample item passes the sine pipe registers (stage a, then stage b) and the result FIFO before out_tvalid.
// Throughput: one item per cycle while in_tready is high; the combinational phase accumulate
// (phase + base step + tone * tone step) feeds the next sample.
// Reset (rst_n low, synchronous): phase, sample/symbol counters, pipeline and
// FIFO cleared, registers to defaults (samples_per_symbol 1); tone table kept.
`include "mfsk_tone_sample_synthesizer_defines.svh"

module mfsk_tone_sample_synthesizer
  import mfsk_tss_pkg::*;
#(
  parameter int TONE_COUNT      = 85,
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] tone_index, [13:7] tone_value, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample (signed Q15)
  output logic        out_tlast,  // last_sample
  output logic        out_tuser,  // [0] exhausted
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SYM_W = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1;
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(TONE_COUNT - 1);
  localparam logic [$clog2(FIFO_DEPTH)+1:0] CREDIT_MAX = ($clog2(FIFO_DEPTH)+2)'(FIFO_DEPTH);

  // ---------------- configuration registers ----------------
  logic [31:0] base_step_r;
  logic [31:0] tone_step_r;
  logic [17:0] sps_r;
  logic [23:0] total_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r <= '0;
      tone_step_r <= '0;
      sps_r       <= 18'd1;
      total_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_STEP: base_step_r <= cfg_data;
        CFG_TONE_STEP: tone_step_r <= cfg_data;
        CFG_SPS:       sps_r       <= cfg_data[17:0];
        CFG_TOTAL:     total_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  op_e        op;
  logic       in_acc;
  logic [6:0] tone_index;
  logic [6:0] tone_value;
  logic       is_load;
  logic       is_sample;
  logic       is_restart;

  assign op         = op_e'(in_tuser);
  assign in_acc     = in_tvalid && in_tready;
  assign tone_index = in_tdata[6:0];
  assign tone_value = in_tdata[13:7];

  always_comb begin
    is_load    = 1'b0;
    is_sample  = 1'b0;
    is_restart = 1'b0;
    case (op)
      OP_LOAD:    is_load    = in_acc;
      OP_SAMPLE:  is_sample  = in_acc;
      OP_RESTART: is_restart = in_acc;
      default: ;
    endcase
  end

  // ---------------- stream state ----------------
  logic [31:0]      phase_r,      phase_nxt;
  logic [23:0]      sample_pos_r, sample_pos_nxt;
  logic [SYM_W-1:0] sym_pos_r,    sym_pos_nxt;
  logic [17:0]      within_r,     within_nxt;

  logic [6:0]       cur_tone;
  logic             samp_exh;
  logic             samp_last;
  logic             samp_go;
  logic [18:0]      within_inc;

  assign samp_exh   = (sample_pos_r >= total_r);
  assign samp_last  = (({1'b0, sample_pos_r} + 25'd1) == {1'b0, total_r});
  assign samp_go    = is_sample && !samp_exh;
  assign within_inc = {1'b0, within_r} + 19'd1;

  // phase accumulate and symbol counting
  always_comb begin
    phase_nxt      = phase_r;
    sample_pos_nxt = sample_pos_r;
    sym_pos_nxt    = sym_pos_r;
    within_nxt     = within_r;
    if (is_restart) begin
      phase_nxt      = '0;
      sample_pos_nxt = '0;
      sym_pos_nxt    = '0;
      within_nxt     = '0;
    end else if (samp_go) begin
      phase_nxt      = phase_r + base_step_r + 32'(cur_tone * tone_step_r);
      sample_pos_nxt = sample_pos_r + 24'd1;
      // a zero symbol length behaves as one: within_inc is at least 1
      if (within_inc >= {1'b0, sps_r}) begin
        within_nxt = '0;
        if (sym_pos_r < SYM_LAST) begin
          sym_pos_nxt = sym_pos_r + SYM_W'(1);
        end
      end else begin
        within_nxt = within_inc[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      sample_pos_r <= '0;
      sym_pos_r    <= '0;
      within_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      sample_pos_r <= sample_pos_nxt;
      sym_pos_r    <= sym_pos_nxt;
      within_r     <= within_nxt;
    end
  end

  // ---------------- tone table ----------------
  // Read address follows the next symbol position so the current tone is
  // ready each cycle; a write to that address in the same cycle is forwarded.
  logic [6:0]       tone_mem [TONE_COUNT];
  logic [6:0]       mem_q_r;
  logic             fwd_hit_r;
  logic [6:0]       fwd_data_r;
  logic             tbl_we;
  logic [SYM_W-1:0] tbl_wa;
  logic [SYM_W-1:0] tbl_ra;

  assign tbl_we   = is_load && (tone_index < 7'(TONE_COUNT));
  assign tbl_wa   = tone_index[SYM_W-1:0];
  assign tbl_ra   = rst_n ? sym_pos_nxt : '0;
  assign cur_tone = fwd_hit_r ? fwd_data_r : mem_q_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tone_mem[tbl_wa] <= tone_value;
    end
    mem_q_r    <= tone_mem[tbl_ra];
    fwd_hit_r  <= tbl_we && (tbl_wa == tbl_ra);
    fwd_data_r <= tone_value;
  end

  // ---------------- sine pipe ----------------
  sample_meta_t               sine_meta_in;
  sample_meta_t               sine_meta_out;
  logic                       sine_valid;
  logic [15:0]                sine_sample;
  logic [1:0]                 inflight;

  assign sine_meta_in.last      = samp_last && !samp_exh;
  assign sine_meta_in.exhausted = samp_exh;

  mfsk_tss_sine #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (is_sample),
    .in_idx    (phase_r[31 -: SINE_INDEX_BITS]),
    .in_meta   (sine_meta_in),
    .out_valid (sine_valid),
    .out_sample(sine_sample),
    .out_meta  (sine_meta_out),
    .inflight  (inflight)
  );

  // ---------------- result FIFO ----------------
  out_item_t                    push_item;
  out_item_t                    head_item;
  logic [$clog2(FIFO_DEPTH):0]  fifo_count;
  logic [$clog2(FIFO_DEPTH)+1:0] credit_used;

  assign push_item.sample    = sine_sample;
  assign push_item.last      = sine_meta_out.last;
  assign push_item.exhausted = sine_meta_out.exhausted;

  mfsk_tss_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (sine_valid),
    .push_item(push_item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (head_item),
    .count    (fifo_count)
  );

  assign out_tdata = head_item.sample;
  assign out_tlast = head_item.last;
  assign out_tuser = head_item.exhausted;

  // accept only out of reset and while every item in the pipe has a FIFO slot
  assign credit_used = {1'b0, fifo_count} + ($clog2(FIFO_DEPTH)+2)'(inflight);
  assign in_tready   = rst_n && (credit_used < CREDIT_MAX);

  // ---------------- assertions ----------------
  `MFSK_ASSERT_IMPL(a_credit, 1'b1, credit_used <= CREDIT_MAX, "result FIFO credit overrun")
  `MFSK_ASSERT_IMPL(a_sym_range, 1'b1, sym_pos_r <= SYM_LAST, "symbol position past table end")
  `MFSK_ASSERT_NEXT(a_pos_step, samp_go, sample_pos_r == $past(sample_pos_r) + 24'd1, "no step")
  `MFSK_ASSERT_NEXT(a_restart, is_restart, !(|{phase_r, sample_pos_r, within_r}), "no restart")
  `MFSK_ASSERT_IMPL(a_exh, out_tvalid && out_tuser, !(|{out_tdata, out_tlast}), "exhausted data")

endmodule

// File: sv/mfsk_tss_sine.sv
// Two-stage sine lookup: quadrant fold, then registered quarter-wave ROM read.
module mfsk_tss_sine
  import mfsk_tss_pkg::*;
#(
  parameter int SINE_INDEX_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [SINE_INDEX_BITS-1:0] in_idx,
  input  sample_meta_t               in_meta,
  output logic                       out_valid,
  output logic [15:0]                out_sample,
  output sample_meta_t               out_meta,
  output logic [1:0]                 inflight
);

  localparam int QW      = SINE_INDEX_BITS - 2;
  localparam int QUARTER = 1 << QW;

  // quarter-wave table, points 0..QUARTER inclusive
  logic [14:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = quarter_sine(k, SINE_INDEX_BITS);
  end

  logic [1:0]  quad;
  logic [QW:0] fold_q;

  // mirror the index in odd quadrants
  always_comb begin
    quad = in_idx[SINE_INDEX_BITS-1 -: 2];
    if (quad[0]) begin
      fold_q = (QW+1)'(QUARTER) - {1'b0, in_idx[QW-1:0]};
    end else begin
      fold_q = {1'b0, in_idx[QW-1:0]};
    end
  end

  logic         a_valid_r;
  logic [QW:0]  a_q_r;
  logic         a_neg_r;
  sample_meta_t a_meta_r;

  logic         b_valid_r;
  logic [14:0]  b_mag_r;
  logic         b_neg_r;
  sample_meta_t b_meta_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  // stage payloads and ROM read
  always_ff @(posedge clk) begin
    a_q_r    <= fold_q;
    a_neg_r  <= quad[1];
    a_meta_r <= in_meta;
    b_mag_r  <= sine_rom[a_q_r];
    b_neg_r  <= a_neg_r;
    b_meta_r <= a_meta_r;
  end

  // sign restore; exhausted items give zero
  always_comb begin
    if (b_meta_r.exhausted) begin
      out_sample = '0;
    end else if (b_neg_r) begin
      out_sample = 16'(17'h10000 - {2'b00, b_mag_r});
    end else begin
      out_sample = {1'b0, b_mag_r};
    end
  end

  assign out_valid = b_valid_r;
  assign out_meta  = b_meta_r;
  assign inflight  = {1'b0, a_valid_r} + {1'b0, b_valid_r};

endmodule

// File: sv/mfsk_tss_fifo.sv
// Small result FIFO in front of the output stream.
module mfsk_tss_fifo
  import mfsk_tss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  output logic [$clog2(FIFO_DEPTH):0] count
);

  localparam int PW = $clog2(FIFO_DEPTH);

  out_item_t      mem [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;
  logic [PW:0]    count_nxt;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfsk_tss_pkg::*;

  localparam int TONES           = 85;
  localparam int SINE_BITS       = 10;
  localparam int QUARTER         = 1 << (SINE_BITS - 2);
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 228;
  localparam int MAX_PRINTED     = 60;
  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Tracks the synthesizer state and the samples it still owes us.
  class tone_synth_tracker;
    bit [31:0] base_step;
    bit [31:0] tone_step;
    bit [17:0] sym_len;
    bit [23:0] total;
    bit [6:0]  tone_tab[TONES];
    bit        written[TONES];
    bit [31:0] phase;
    bit [23:0] sample_pos;
    bit [6:0]  symbol_pos;
    bit [17:0] in_symbol;
    bit [15:0] quarter_mag[QUARTER + 1];
    out_item_t due_samples[$];
    int unsigned mismatches;

    // quarter-wave Q15 magnitudes, Taylor series to x^11 with truncating shifts
    function new();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] t;
      bit [63:0] s;
      bit [63:0] v;
      sym_len = 18'd1;
      for (int q = 0; q <= QUARTER; q++) begin
        x  = (64'(q) * HALF_PI_Q30) >> (SINE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 5; k >= 1; k--) begin
          t = Q30_ONE - ((x2 * t) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
        end
        s = (x * t) >> 30;
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        quarter_mag[q] = (v > 64'd32767) ? 16'd32767 : v[15:0];
      end
    endfunction

    function bit [15:0] sine_of(bit [31:0] ph);
      bit [SINE_BITS-1:0] idx;
      bit [SINE_BITS-3:0] r;
      bit [15:0]          mag;
      idx = ph[31 -: SINE_BITS];
      r   = idx[SINE_BITS-3:0];
      mag = idx[SINE_BITS-2] ? quarter_mag[QUARTER - int'(r)] : quarter_mag[r];
      return idx[SINE_BITS-1] ? -mag : mag;
    endfunction

    function void set_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        CFG_BASE_STEP: base_step = value;
        CFG_TONE_STEP: tone_step = value;
        CFG_SPS:       sym_len   = value[17:0];
        CFG_TOTAL:     total     = value[23:0];
        default: ;
      endcase
    endfunction

    // table slot the next sample would read while still unwritten, else -1
    function int entry_to_load();
      int sp;
      if (sample_pos >= total) return -1;
      sp = (symbol_pos >= TONES) ? TONES - 1 : int'(symbol_pos);
      return written[sp] ? -1 : sp;
    endfunction

    function out_item_t advance_sample();
      out_item_t r;
      int        sp;
      bit [17:0] eff_len;
      r = '0;
      if (sample_pos >= total) begin
        r.exhausted = 1'b1;
        return r;
      end
      sp      = (symbol_pos >= TONES) ? TONES - 1 : int'(symbol_pos);
      eff_len = (sym_len == 0) ? 18'd1 : sym_len;
      r.sample = sine_of(phase);
      r.last   = ({1'b0, sample_pos} + 25'd1) == {1'b0, total};
      phase = phase + base_step + 32'(tone_tab[sp]) * tone_step;
      in_symbol++;
      if (in_symbol >= eff_len) begin
        in_symbol = '0;
        if (symbol_pos < TONES - 1) symbol_pos++;
        else symbol_pos = 7'(TONES - 1);
      end
      sample_pos++;
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic [6:0] idx, logic [6:0] val);
      case (op)
        OP_LOAD: begin
          if (idx < TONES) begin
            tone_tab[idx] = val;
            written[idx]  = 1'b1;
          end
        end
        OP_RESTART: begin
          phase      = '0;
          sample_pos = '0;
          symbol_pos = '0;
          in_symbol  = '0;
        end
        OP_SAMPLE: due_samples.push_back(advance_sample());
        default: ;
      endcase
    endfunction

    // one line per mismatch; printing stops after a while, counting does not
    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [15:0] sample, logic last, logic exhausted);
      out_item_t want;
      if (due_samples.size() == 0) begin
        report($sformatf("result with none pending: sample %h", sample));
        return;
      end
      want = due_samples.pop_front();
      if (sample !== want.sample)
        report($sformatf("sample %h, want %h", sample, want.sample));
      if (last !== want.last)
        report($sformatf("last_sample %b, want %b", last, want.last));
      if (exhausted !== want.exhausted)
        report($sformatf("exhausted %b, want %b", exhausted, want.exhausted));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tone_synth_tracker synth = new();

  int unsigned gap_pct     = 25;
  int unsigned stall_pct   = 25;
  int unsigned restart_pct = 5;
  bit          hold_off_req;
  int unsigned idle_cycles;

  mfsk_tone_sample_synthesizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one item on the input stream, then maybe a gap
  task automatic send_item(logic [1:0] op, logic [6:0] idx, logic [6:0] val);
    in_tuser  <= op;
    in_tdata  <= {2'b00, val, idx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    synth.note_input(op, idx, val);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // a sample never reads a table slot that was not loaded
  task automatic send_sample();
    int slot;
    slot = synth.entry_to_load();
    if (slot >= 0) send_item(OP_LOAD, 7'(slot), 7'($urandom_range(0, 127)));
    send_item(OP_SAMPLE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic send_random_item(output int counted);
    int unsigned pick;
    logic [6:0]  idx;
    logic [6:0]  val;
    pick    = $urandom_range(1, 100);
    counted = 1;
    idx     = 7'($urandom_range(0, 127));
    val     = 7'($urandom_range(0, 127));
    if (pick <= restart_pct) begin
      send_item(OP_RESTART, idx, val);
    end else if (pick <= restart_pct + 3) begin
      send_item(OP_UNUSED, idx, val);
      counted = 0;
    end else if (pick <= restart_pct + 21) begin
      idx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(TONES, 127))
                                        : 7'($urandom_range(0, TONES - 1));
      val = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(65, 127))
                                        : 7'($urandom_range(0, 64));
      send_item(OP_LOAD, idx, val);
      if (idx >= TONES) counted = 0;
    end else begin
      send_sample();
    end
  endtask

  // stop sending, let all pending samples come out, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (synth.due_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    synth.set_reg(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] base, logic [31:0] tone, logic [17:0] len,
                            logic [23:0] count);
    write_reg(CFG_BASE_STEP, base);
    write_reg(CFG_TONE_STEP, tone);
    write_reg(CFG_SPS, 32'(len));
    write_reg(CFG_TOTAL, 32'(count));
  endtask

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      synth.check_result(out_tdata, out_tlast, out_tuser);
  end

  // watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)
        || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    int issued;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE_STEP;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers leave the stream exhausted; ignored items
    send_sample();
    send_item(OP_UNUSED, 7'h7F, 7'h7F);
    send_item(OP_LOAD, 7'h7F, 7'h7F);
    send_item(OP_LOAD, 7'(TONES), 7'd3);
    drain_results();

    // zero symbol length acts as one; six-sample transmission
    set_config(32'h0400_0000, 32'h0100_0000, 18'd0, 24'd6);
    send_item(OP_LOAD, 7'd0, 7'd0);
    send_item(OP_LOAD, 7'd1, 7'd64);
    send_item(OP_LOAD, 7'd2, 7'd127);
    send_item(OP_LOAD, 7'd3, 7'd1);
    send_item(OP_LOAD, 7'd4, 7'd42);
    send_item(OP_LOAD, 7'd5, 7'd9);
    send_item(OP_LOAD, 7'(TONES - 1), 7'd64);
    // last one flagged on the sixth, exhausted on the seventh
    repeat (7) send_sample();
    send_item(OP_RESTART, 7'd0, 7'd0);
    repeat (2) send_sample();

    // random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        0: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'd1, 24'hFF_FFFF);
        1: set_config(32'd0, 32'd0, 18'h3FFFF, 24'($urandom_range(100, 300)));
        default: begin
          set_config(($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 24)),
                     ($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 22)),
                     ($urandom_range(0, 3) == 0) ? 18'($urandom_range(0, 40))
                                                 : 18'($urandom_range(0, 4)),
                     ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                 : 24'($urandom_range(0, 400)));
        end
      endcase
      // no idling at all in the final phase
      if (p == 7) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      // first phase runs past the end of the symbol table
      restart_pct = (p == 0) ? 0 : 5;
      if (p != 0 && $urandom_range(0, 1) == 1) send_item(OP_RESTART, 7'd0, 7'd0);
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        if (p == 3 && issued == 60) hold_off_req = 1'b1;
        if (p == 5 && issued == 100) drain_results();
        send_random_item(counted);
        issued += counted;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (synth.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
